// ===== rtl/core/chaikin_curve_smoother_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the Chaikin curve smoother
// Two shorthands for clocked checks; each expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef CHAIKIN_CURVE_SMOOTHER_ASSERT_SVH
`define CHAIKIN_CURVE_SMOOTHER_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define CCS_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A consequence that must hold in the cycle after its trigger.
`define CCS_ASSERT_NEXT(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/ccs_pkg.sv =====
// ----------------------------------------------------------------------------
// Chaikin curve smoother package
// Shared widths, the point record, the front state type and the weighting.
// ----------------------------------------------------------------------------
package ccs_pkg;

    localparam int MAX_PASSES  = 4;
    localparam int COORD_BITS  = 32;
    localparam int PASS_BITS   = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);
    localparam int SLOT_COUNT  = 3;
    localparam int SLOT_BITS   = 2;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic                         last;
        logic                         raw;
    } pt_t;

    typedef enum logic [1:0] {
        FS_IDLE,
        FS_ONE,
        FS_HELD,
        FS_STREAM
    } front_state_t;

    // floor((3a + b) / 4), exact in a two-bit wider sum.
    function automatic logic signed [COORD_BITS-1:0] weigh(
        input logic signed [COORD_BITS-1:0] a,
        input logic signed [COORD_BITS-1:0] b
    );
        logic signed [COORD_BITS+1:0] sum;
        sum = {{2{a[COORD_BITS-1]}}, a}
            + {a[COORD_BITS-1], a, 1'b0}
            + {{2{b[COORD_BITS-1]}}, b};
        return sum[COORD_BITS+1:2];
    endfunction

endpackage

// ===== rtl/core/ccs_queue.sv =====
// ----------------------------------------------------------------------------
// Point queue
// Short first-in first-out buffer between the front part and the passes.
// ----------------------------------------------------------------------------
module ccs_queue
    import ccs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    input  pt_t  push_pt,
    output logic full,
    output logic pop_valid,
    input  logic pop_ready,
    output pt_t  pop_pt
);

    pt_t                  mem_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg;
    logic [QPTR_BITS-1:0] wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg;
    logic [QPTR_BITS-1:0] rd_ptr_next;
    logic [QCNT_BITS-1:0] count_reg;
    logic [QCNT_BITS-1:0] count_next;
    logic                 push;
    logic                 pop;

    assign full      = (count_reg == QCNT_BITS'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_pt    = mem_reg[rd_ptr_reg];
    assign push      = push_valid && !full;
    assign pop       = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_pt;
        end
    end

endmodule

// ===== rtl/core/ccs_front.sv =====
// ----------------------------------------------------------------------------
// Smoother front part
// Accepts input points, tracks the position in the path and queues work.
// ----------------------------------------------------------------------------
module ccs_front
    import ccs_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [COORD_BITS-1:0] x_coord,
    input  logic signed [COORD_BITS-1:0] y_coord,
    input  logic                         path_end,
    output logic                         push_valid,
    output pt_t                          push_pt,
    input  logic                         push_full
);

    front_state_t                 state_reg;
    front_state_t                 state_next;
    logic signed [COORD_BITS-1:0] held_x_reg;
    logic signed [COORD_BITS-1:0] held_y_reg;
    logic                         take;
    logic                         hold;

    // The second point waits until a third shows the path goes on.
    assign take = in_valid && !in_stall;
    assign hold = (state_reg == FS_ONE) && take && !path_end;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            FS_IDLE:
            begin
                if (take && !path_end)
                begin
                    state_next = FS_ONE;
                end
            end
            FS_ONE:
            begin
                if (take)
                begin
                    state_next = path_end ? FS_IDLE : FS_HELD;
                end
            end
            FS_HELD:
            begin
                if (push_valid)
                begin
                    state_next = FS_STREAM;
                end
            end
            FS_STREAM:
            begin
                if (take && path_end)
                begin
                    state_next = FS_IDLE;
                end
            end
            default:
            begin
                state_next = FS_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall     = push_full || (state_reg == FS_HELD);
        push_valid   = 1'b0;
        push_pt.x    = x_coord;
        push_pt.y    = y_coord;
        push_pt.last = path_end;
        push_pt.raw  = 1'b0;
        unique case (state_reg)
            FS_IDLE, FS_STREAM:
            begin
                push_valid = in_valid && !in_stall;
            end
            FS_ONE:
            begin
                // A two-point path leaves unchanged.
                push_valid  = in_valid && !in_stall && path_end;
                push_pt.raw = 1'b1;
            end
            FS_HELD:
            begin
                push_valid   = in_valid && !push_full;
                push_pt.x    = held_x_reg;
                push_pt.y    = held_y_reg;
                push_pt.last = 1'b0;
            end
            default:
            begin
                push_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hold)
        begin
            held_x_reg <= x_coord;
            held_y_reg <= y_coord;
        end
    end

endmodule

// ===== rtl/core/ccs_pass.sv =====
// ----------------------------------------------------------------------------
// Corner-cutting pass
// One refinement level: turns each segment into its quarter points.
// ----------------------------------------------------------------------------
`include "chaikin_curve_smoother_assert.svh"

module ccs_pass
    import ccs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic active,
    input  logic in_valid,
    output logic in_ready,
    input  pt_t  in_pt,
    output logic out_valid,
    input  logic out_ready,
    output pt_t  out_pt
);

    logic                         started_reg;
    logic                         started_next;
    logic signed [COORD_BITS-1:0] prev_x_reg;
    logic signed [COORD_BITS-1:0] prev_y_reg;
    pt_t                          slot_reg [SLOT_COUNT];
    pt_t                          slot_next [SLOT_COUNT];
    logic [SLOT_BITS-1:0]         left_reg;
    logic [SLOT_BITS-1:0]         left_next;
    logic                         take;
    logic                         pop;
    logic                         track;
    logic                         expand;

    // A pass-through point from the front is never smoothed.
    assign track     = active && !in_pt.raw;
    assign expand    = track && started_reg;
    assign out_valid = (left_reg != '0);
    assign out_pt    = slot_reg[0];
    assign in_ready  = (left_reg == '0) || ((left_reg == SLOT_BITS'(1)) && out_ready);
    assign take      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        slot_next = slot_reg;
        left_next = left_reg;
        if (take)
        begin
            if (expand)
            begin
                slot_next[0].x    = weigh(prev_x_reg, in_pt.x);
                slot_next[0].y    = weigh(prev_y_reg, in_pt.y);
                slot_next[0].last = 1'b0;
                slot_next[0].raw  = 1'b0;
                slot_next[1].x    = weigh(in_pt.x, prev_x_reg);
                slot_next[1].y    = weigh(in_pt.y, prev_y_reg);
                slot_next[1].last = 1'b0;
                slot_next[1].raw  = 1'b0;
                slot_next[2].x    = in_pt.x;
                slot_next[2].y    = in_pt.y;
                slot_next[2].last = 1'b1;
                slot_next[2].raw  = 1'b0;
                left_next = in_pt.last ? SLOT_BITS'(3) : SLOT_BITS'(2);
            end
            else
            begin
                slot_next[0] = in_pt;
                left_next    = SLOT_BITS'(1);
            end
        end
        else if (pop)
        begin
            for (int i = 0; i < SLOT_COUNT - 1; i++)
            begin
                slot_next[i] = slot_reg[i + 1];
            end
            left_next = left_reg - 1'b1;
        end
    end

    always_comb
    begin
        started_next = started_reg;
        if (take && in_pt.last)
        begin
            started_next = 1'b0;
        end
        else if (take && track)
        begin
            started_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg <= 1'b0;
            left_reg    <= '0;
            prev_x_reg  <= '0;
            prev_y_reg  <= '0;
        end
        else
        begin
            started_reg <= started_next;
            left_reg    <= left_next;
            if (take && track)
            begin
                prev_x_reg <= in_pt.x;
                prev_y_reg <= in_pt.y;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

    `CCS_ASSERT_NEXT(a_pass_single, take && !expand, left_reg == SLOT_BITS'(1), "pass-through point must yield one result")
    `CCS_ASSERT_NEXT(a_pass_split, take && expand, left_reg == ($past(in_pt.last) ? SLOT_BITS'(3) : SLOT_BITS'(2)), "segment must yield its quarter points")
    `CCS_ASSERT_NEXT(a_pass_end_clears, take && in_pt.last, !started_reg, "path end must reset the pass")
    `CCS_ASSERT_NEXT(a_pass_idle_holds, take && !track, $stable(prev_x_reg) && $stable(prev_y_reg), "bypassed pass must keep its last point")

endmodule

// ===== rtl/core/chaikin_curve_smoother.sv =====
// ----------------------------------------------------------------------------
// Chaikin curve smoother
// Streams a polyline through up to four cascaded corner-cutting passes.
// ----------------------------------------------------------------------------
// Points enter one per transfer on the input channel, signed Q16.16, with
// path_end on the last point of each path; the smoothed path leaves one point
// per transfer with out_end on its last point. smoothing_passes (0 to 4,
// larger values act as 4) is written through the cfg channel, which is always
// ready; write it only while the block is idle. With P passes every interior
// point turns into 2^P output points and the output register of the last pass
// delivers one point per cycle while out_stall is low, so the input rate is
// set by the output port; the passes refill their buffers without a bubble.
// The third point of each path is stalled while the held second point is
// queued ahead of it. A four-entry queue lets the input side keep taking
// points while earlier ones are still being refined. The first result of an
// input transfer is registered once by the queue and once by each of the
// four passes, active or not, whatever P is.
// ----------------------------------------------------------------------------
module chaikin_curve_smoother
    import ccs_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [PASS_BITS-1:0]         cfg_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [COORD_BITS-1:0] x_coord,
    input  logic signed [COORD_BITS-1:0] y_coord,
    input  logic                         path_end,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [COORD_BITS-1:0] out_x,
    output logic signed [COORD_BITS-1:0] out_y,
    output logic                         out_end
);

    logic [PASS_BITS-1:0] smoothing_passes_reg;
    logic [PASS_BITS-1:0] smoothing_passes_next;
    logic [PASS_BITS-1:0] passes_eff;
    logic                 push_valid;
    pt_t                  push_pt;
    logic                 queue_full;
    logic                 stage_valid [MAX_PASSES + 1];
    logic                 stage_ready [MAX_PASSES + 1];
    pt_t                  stage_pt [MAX_PASSES + 1];
    logic                 stage_active [MAX_PASSES];

    // The configuration register takes every write transfer.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        smoothing_passes_next = smoothing_passes_reg;
        if (cfg_valid && cfg_ready)
        begin
            smoothing_passes_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smoothing_passes_reg <= '0;
        end
        else
        begin
            smoothing_passes_reg <= smoothing_passes_next;
        end
    end

    // Counts above the number of built passes saturate.
    assign passes_eff = (smoothing_passes_reg > PASS_BITS'(MAX_PASSES))
                      ? PASS_BITS'(MAX_PASSES) : smoothing_passes_reg;

    // The front decides, per input point, what the passes must see: the
    // point itself, the held second point followed by the third, or a
    // pass-through for a path of two points.
    ccs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .x_coord    (x_coord),
        .y_coord    (y_coord),
        .path_end   (path_end),
        .push_valid (push_valid),
        .push_pt    (push_pt),
        .push_full  (queue_full)
    );

    ccs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_pt    (push_pt),
        .full       (queue_full),
        .pop_valid  (stage_valid[0]),
        .pop_ready  (stage_ready[0]),
        .pop_pt     (stage_pt[0])
    );

    // Each pass is a stream stage with its own result buffer. A pass at or
    // beyond the active count forwards points unchanged, one for one.
    for (genvar g = 0; g < MAX_PASSES; g++)
    begin : g_pass
        assign stage_active[g] = (PASS_BITS'(g) < passes_eff);

        ccs_pass u_pass (
            .clk       (clk),
            .rst_n     (rst_n),
            .active    (stage_active[g]),
            .in_valid  (stage_valid[g]),
            .in_ready  (stage_ready[g]),
            .in_pt     (stage_pt[g]),
            .out_valid (stage_valid[g + 1]),
            .out_ready (stage_ready[g + 1]),
            .out_pt    (stage_pt[g + 1])
        );
    end

    // The last pass buffer is the output register.
    assign stage_ready[MAX_PASSES] = !out_stall;
    assign out_valid               = stage_valid[MAX_PASSES];
    assign out_x                   = stage_pt[MAX_PASSES].x;
    assign out_y                   = stage_pt[MAX_PASSES].y;
    assign out_end                 = stage_pt[MAX_PASSES].last;

endmodule
